// File: rtl/core/emt_pkg.sv
// shared types and constants of the entity mask table engine
package emt_pkg;

	localparam int WORD_W = 32;
	localparam int ID_W   = 6;
	localparam int BIT_W  = 5;
	localparam int CNT_W  = 7;
	localparam int MODE_W = 4;

	typedef enum logic [MODE_W-1:0] {
		MODE_CREATE   = 4'd0,
		MODE_DELETE   = 4'd1,
		MODE_DUP      = 4'd2,
		MODE_ADD_COMP = 4'd3,
		MODE_REM_COMP = 4'd4,
		MODE_SET_FLAG = 4'd5,
		MODE_CLR_FLAG = 4'd6,
		MODE_HAS_COMP = 4'd7,
		MODE_HAS_FLAG = 4'd8,
		MODE_QUERY    = 4'd9
	} mode_t;

	typedef enum logic [1:0] {
		ST_OK   = 2'd0,
		ST_FULL = 2'd1,
		ST_DEAD = 2'd2
	} status_t;

	typedef enum logic {
		CFG_ALIVE_BIT = 1'b0,
		CFG_INFO_BIT  = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		logic [WORD_W-1:0] mask;
		logic [WORD_W-1:0] flags;
	} entry_t;

endpackage

// File: rtl/core/entity_mask_table_engine.sv
// top level: entity signature table with create, delete, bit operations and query scan
//
// Each entity owns a 32-bit component mask and a 32-bit flag word held in one
// synchronous entry memory; a second memory stacks freed identifiers for reuse.
// An operation is taken on the s_ side, one at a time. Create, delete, duplicate,
// set, clear and test read the entry (and the top of the freed stack) in the
// transfer cycle and write back in the execute state once the result register is
// free; the next operation is taken only after that write-back. A query streams
// the table through the memory read port, one entity per cycle unless a match
// waits on a busy result register; the next transfer is taken once its final
// result is loaded. Each match is held back until a later one is found so that
// the final one can carry tlast, and a query with no match gives a single result
// with hit low. Results sit in an output register, so the next operation is taken
// while the last result still waits on m_tready. Reset needs no clearing pass:
// per-entry valid bits make unwritten entries read as zero. Write configuration
// only while idle.
module entity_mask_table_engine
	import emt_pkg::*;
#(
	parameter int ENTITIES = 64
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write port
	input  logic        cfg_wr_en,
	input  logic        cfg_index,
	input  logic [4:0]  cfg_wr_data,
	// operation stream
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,   // mode, entity_id, bit_index, query_mask, query_flags, pad
	// result stream
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // result_entity, hit, status, pad
	output logic        m_tlast
);

	localparam int AW = (ENTITIES > 1) ? $clog2(ENTITIES) : 1;

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_SCAN, S_FINISH} state_t;

	// input field slices
	logic [MODE_W-1:0] in_mode;
	logic [ID_W-1:0]   in_id;
	logic [BIT_W-1:0]  in_bit;
	logic [WORD_W-1:0] in_qmask;
	logic [WORD_W-1:0] in_qflags;

	assign in_mode   = s_tdata[3:0];
	assign in_id     = s_tdata[9:4];
	assign in_bit    = s_tdata[14:10];
	assign in_qmask  = s_tdata[46:15];
	assign in_qflags = s_tdata[78:47];

	// control state
	state_t            state_q;
	logic [CNT_W-1:0]  hw_q;        // identifiers ever issued
	logic [CNT_W-1:0]  fd_q;        // freed stack depth
	logic [BIT_W-1:0]  alive_bit_q;
	logic [BIT_W-1:0]  info_bit_q;
	logic [CNT_W-1:0]  idx_q;       // next entity to read in a scan
	logic [CNT_W-1:0]  limit_q;
	logic              chk_v_s1;    // read data of idx_s1 is at the memory output
	logic [ID_W-1:0]   idx_s1;
	logic              pend_q;      // a match is held back awaiting its last flag
	logic [ID_W-1:0]   pend_id_q;

	// latched operation
	logic [MODE_W-1:0] mode_q;
	logic [ID_W-1:0]   id_q;
	logic [BIT_W-1:0]  bit_q;
	logic [WORD_W-1:0] qmask_q;
	logic [WORD_W-1:0] qflags_q;

	// result register
	logic              out_valid_q;
	logic [ID_W-1:0]   out_ent_q;
	logic              out_hit_q;
	status_t           out_status_q;
	logic              out_last_q;

	logic              accept;
	logic              out_free;

	assign s_tready = (state_q == S_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign out_free = !out_valid_q || m_tready;

	// memory ports
	logic              ent_rd_en;
	logic [AW-1:0]     ent_rd_addr;
	entry_t            ent_rd_data;
	logic              ent_we;
	logic [AW-1:0]     ent_wa;
	logic              ent_wv;
	entry_t            ent_wd;
	logic              stk_we;
	logic [AW-1:0]     stk_wa;
	logic [AW-1:0]     stk_rd_data;
	logic [CNT_W-1:0]  fd_m1;

	// scan datapath
	logic              match;
	logic              stall;
	logic              issue;

	assign match = chk_v_s1 && (state_q == S_SCAN)
		&& ((ent_rd_data.flags & qflags_q) == qflags_q)
		&& ((ent_rd_data.mask & qmask_q) == qmask_q);
	// a second match cannot push the held one out while the result register is busy
	assign stall = match && pend_q && !out_free;
	assign issue = (state_q == S_SCAN) && !stall && (idx_q < limit_q);

	assign ent_rd_en   = accept || issue;
	assign ent_rd_addr = accept ? in_id[AW-1:0] : idx_q[AW-1:0];
	assign fd_m1       = fd_q - CNT_W'(1);

	// single operation execute
	logic              commit;
	logic              ok;
	entry_t            src;
	logic [WORD_W-1:0] bitv;
	logic [WORD_W-1:0] alive_v;
	logic [WORD_W-1:0] info_v;
	logic              can_pop;
	logic              can_fresh;
	logic [AW-1:0]     new_id;
	logic [ID_W-1:0]   ex_ent;
	logic              ex_hit;
	status_t           ex_status;
	logic              we_raw;
	logic              push_raw;
	logic              pop;
	logic              fresh;

	assign commit = (state_q == S_EXEC) && out_free;

	always_comb begin
		ok        = ({1'b0, id_q} < CNT_W'(ENTITIES));
		src       = ok ? ent_rd_data : '0;
		bitv      = WORD_W'(1) << bit_q;
		alive_v   = WORD_W'(1) << alive_bit_q;
		info_v    = WORD_W'(1) << info_bit_q;
		can_pop   = (fd_q != '0);
		can_fresh = (hw_q < CNT_W'(ENTITIES));
		new_id    = can_pop ? stk_rd_data : hw_q[AW-1:0];
		ex_ent    = id_q;
		ex_hit    = 1'b0;
		ex_status = ST_OK;
		we_raw    = 1'b0;
		push_raw  = 1'b0;
		pop       = 1'b0;
		fresh     = 1'b0;
		ent_wa    = id_q[AW-1:0];
		ent_wv    = 1'b1;
		ent_wd    = src;
		case (mode_q)
			MODE_CREATE, MODE_DUP: begin
				if (can_pop || can_fresh) begin
					we_raw = 1'b1;
					pop    = can_pop;
					fresh  = !can_pop;
					ent_wa = new_id;
					ex_ent = ID_W'(new_id);
					if (mode_q == MODE_CREATE) begin
						ent_wd.mask  = info_v;
						ent_wd.flags = alive_v;
					end
				end else begin
					ex_ent    = '0;
					ex_status = ST_FULL;
				end
			end
			MODE_DELETE: begin
				if (ok && ((src.flags & alive_v) != '0)) begin
					we_raw   = 1'b1;
					ent_wv   = 1'b0;
					ent_wd   = '0;
					push_raw = (fd_q < CNT_W'(ENTITIES));
				end else begin
					ex_status = ST_DEAD;
				end
			end
			MODE_ADD_COMP: begin
				we_raw      = ok;
				ent_wd.mask = src.mask | bitv;
			end
			MODE_REM_COMP: begin
				we_raw      = ok;
				ent_wd.mask = src.mask & ~bitv;
			end
			MODE_SET_FLAG: begin
				we_raw       = ok;
				ent_wd.flags = src.flags | bitv;
			end
			MODE_CLR_FLAG: begin
				we_raw       = ok;
				ent_wd.flags = src.flags & ~bitv;
			end
			MODE_HAS_COMP: ex_hit = ((src.mask & bitv) != '0);
			MODE_HAS_FLAG: ex_hit = ((src.flags & bitv) != '0);
			default: ex_ent = '0;
		endcase
	end

	assign ent_we = we_raw && commit;
	assign stk_we = push_raw && commit;
	assign stk_wa = fd_q[AW-1:0];

	emt_entity_ram #(
		.DEPTH (ENTITIES),
		.AW    (AW)
	) u_entity_ram (
		.clk      (clk),
		.arst_n   (arst_n),
		.rd_en    (ent_rd_en),
		.rd_addr  (ent_rd_addr),
		.rd_data  (ent_rd_data),
		.wr_en    (ent_we),
		.wr_addr  (ent_wa),
		.wr_valid (ent_wv),
		.wr_data  (ent_wd)
	);

	// the top of the stack is read with every transfer, used by create and duplicate
	emt_free_stack #(
		.DEPTH (ENTITIES),
		.AW    (AW)
	) u_free_stack (
		.clk     (clk),
		.wr_en   (stk_we),
		.wr_addr (stk_wa),
		.wr_data (id_q[AW-1:0]),
		.rd_en   (accept),
		.rd_addr (fd_m1[AW-1:0]),
		.rd_data (stk_rd_data)
	);

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_bit_q <= '0;
			info_bit_q  <= '0;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				CFG_ALIVE_BIT: alive_bit_q <= cfg_wr_data;
				CFG_INFO_BIT:  info_bit_q  <= cfg_wr_data;
				default: ;
			endcase
		end
	end

	// operation latch, alive bit folded into the query flags
	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q   <= in_mode;
			id_q     <= in_id;
			bit_q    <= in_bit;
			qmask_q  <= in_qmask;
			qflags_q <= in_qflags | (WORD_W'(1) << alive_bit_q);
		end
	end

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			hw_q         <= '0;
			fd_q         <= '0;
			idx_q        <= '0;
			limit_q      <= '0;
			chk_v_s1     <= 1'b0;
			idx_s1       <= '0;
			pend_q       <= 1'b0;
			pend_id_q    <= '0;
			out_valid_q  <= 1'b0;
			out_ent_q    <= '0;
			out_hit_q    <= 1'b0;
			out_status_q <= ST_OK;
			out_last_q   <= 1'b0;
		end else begin
			if (m_tready)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (in_mode == MODE_QUERY) begin
							state_q  <= S_SCAN;
							idx_q    <= '0;
							limit_q  <= hw_q;
							chk_v_s1 <= 1'b0;
							pend_q   <= 1'b0;
						end else begin
							state_q <= S_EXEC;
						end
					end
				end
				S_EXEC: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_ent_q    <= ex_ent;
						out_hit_q    <= ex_hit;
						out_status_q <= ex_status;
						out_last_q   <= 1'b1;
						if (fresh)
							hw_q <= hw_q + CNT_W'(1);
						if (pop)
							fd_q <= fd_m1;
						else if (push_raw)
							fd_q <= fd_q + CNT_W'(1);
						state_q <= S_IDLE;
					end
				end
				S_SCAN: begin
					if (!stall) begin
						chk_v_s1 <= issue;
						idx_s1   <= idx_q[ID_W-1:0];
						if (issue)
							idx_q <= idx_q + CNT_W'(1);
						if (match) begin
							// the held match is known not to be the last one
							if (pend_q) begin
								out_valid_q  <= 1'b1;
								out_ent_q    <= pend_id_q;
								out_hit_q    <= 1'b1;
								out_status_q <= ST_OK;
								out_last_q   <= 1'b0;
							end
							pend_q    <= 1'b1;
							pend_id_q <= idx_s1;
						end
						if (!chk_v_s1 && (idx_q == limit_q))
							state_q <= S_FINISH;
					end
				end
				S_FINISH: begin
					if (out_free) begin
						out_valid_q  <= 1'b1;
						out_ent_q    <= pend_q ? pend_id_q : '0;
						out_hit_q    <= pend_q;
						out_status_q <= ST_OK;
						out_last_q   <= 1'b1;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {7'd0, out_status_q, out_hit_q, out_ent_q};
	assign m_tlast  = out_last_q;

`ifndef NO_ASSERTIONS
	// a read never meets a write to the same entry in the same cycle
	a_no_rw_clash: assert property (@(posedge clk) disable iff (!arst_n)
		(ent_we && ent_rd_en) |-> (ent_wa != ent_rd_addr))
		else $error("entry read and write collide");

	a_hw_bound: assert property (@(posedge clk) disable iff (!arst_n)
		hw_q <= CNT_W'(ENTITIES))
		else $error("high-water count beyond table");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (idx_q <= limit_q))
		else $error("scan index beyond limit");

	// a stalled scan keeps its read data in place
	a_scan_hold: assert property (@(posedge clk) disable iff (!arst_n)
		stall |=> (chk_v_s1 && $stable(idx_s1) && $stable(ent_rd_data)))
		else $error("scan data lost during stall");
`endif

endmodule

// File: rtl/core/emt_entity_ram.sv
// entity entry memory with per-entry valid bits and registered read
module emt_entity_ram
	import emt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output entry_t        rd_data,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic          wr_valid,
	input  entry_t        wr_data
);

	entry_t             mem_q [DEPTH];
	logic [DEPTH-1:0]   valid_q;
	entry_t             rdata_q;
	logic               rvalid_q;

	// entries not yet written since reset read as all zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (wr_en)
				valid_q[wr_addr] <= wr_valid;
			if (rd_en)
				rvalid_q <= valid_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rdata_q <= mem_q[rd_addr];
	end

	assign rd_data = rvalid_q ? rdata_q : '0;

endmodule

// File: rtl/core/emt_free_stack.sv
// storage of recycled entity identifiers, registered read
module emt_free_stack
	import emt_pkg::*;
#(
	parameter int DEPTH = 64,
	parameter int AW    = 6
) (
	input  logic          clk,
	input  logic          wr_en,
	input  logic [AW-1:0] wr_addr,
	input  logic [AW-1:0] wr_data,
	input  logic          rd_en,
	input  logic [AW-1:0] rd_addr,
	output logic [AW-1:0] rd_data
);

	logic [AW-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en)
			mem_q[wr_addr] <= wr_data;
		if (rd_en)
			rd_data <= mem_q[rd_addr];
	end

endmodule
